/* sv/bromm_pkg.sv */
// ----------------------------------------------------------------------------
// Banked ROM mapper package
// Request kinds, mapper command codes, reset values and the request and
// response payload types shared by the mapper core and its parts.
// ----------------------------------------------------------------------------
package bromm_pkg;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_WRITE    = 2'd0,
      KIND_TICK     = 2'd1,
      KIND_CPU_LOOK = 2'd2,
      KIND_PPU_LOOK = 2'd3
   } kind_type;

   // Mapper commands latched by a write below the data port
   localparam logic [3:0] CMD_WINDOW   = 4'h8;
   localparam logic [3:0] CMD_PRG_8000 = 4'h9;
   localparam logic [3:0] CMD_PRG_A000 = 4'hA;
   localparam logic [3:0] CMD_PRG_C000 = 4'hB;
   localparam logic [3:0] CMD_MIRROR   = 4'hC;
   localparam logic [3:0] CMD_IRQ_CTRL = 4'hD;
   localparam logic [3:0] CMD_CNT_LO   = 4'hE;
   localparam logic [3:0] CMD_CNT_HI   = 4'hF;

   // Address boundaries
   localparam logic [15:0] ADDR_DATA_PORT = 16'hA000;
   localparam logic [15:0] ADDR_IGNORED   = 16'hC000;
   localparam logic [15:0] ADDR_FIXED     = 16'hE000;
   localparam logic [15:0] ADDR_PRG       = 16'h8000;
   localparam logic [15:0] ADDR_WINDOW    = 16'h6000;
   localparam logic [15:0] ADDR_PPU_TOP   = 16'h2000;

   // Line counter
   localparam logic [15:0] LINE_CYCLES = 16'd114;
   localparam logic [15:0] CNT_RELOAD  = 16'hFFFF;

   // Reset values
   localparam logic [5:0] LAST_PRG_RESET = 6'd63;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  data;
   } req_item_type;

   typedef struct packed {
      logic       irq;
      logic [7:0] bank;
      logic       ram_selected;
      logic [1:0] mirroring;
   } rsp_item_type;

endpackage

/* sv/banked_rom_mapper_with_line_irq_core.sv */
// ----------------------------------------------------------------------------
// Banked ROM mapper with line IRQ
// Cartridge bank mapper: command/data register writes, line-counted IRQ
// and CPU/PPU bank lookups, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one request: kind (register write, line tick, CPU lookup,
//          PPU pattern lookup), a 16-bit address and a data byte.
//   rsp_*  returns exactly one response per request: irq pulse, bank number,
//          RAM select and the current mirroring mode, in request order.
//   csr_*  writes the fixed top program bank; it is always ready. Write it only
//          while no request is in flight; the block itself does not enforce it.
// Path: an accepted request is held in the request register, then applied
//   as it moves into the result register, which drives rsp_*.
// Throughput: one request per cycle while the receiver takes responses; a
//   request register feeds the mapper logic, whose response lands in a result register.
// Reset clears the mapper state, sets the top bank to 63 and empties both
//   registers. When the receiver stalls the response holds, the request
//   register still takes one more request, and req_ready then drops.
// ----------------------------------------------------------------------------
module banked_rom_mapper_with_line_irq_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_irq,
   output logic [7:0]  rsp_bank,
   output logic        rsp_ram_selected,
   output logic [1:0]  rsp_mirroring,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_last_prg_bank
);

   logic                    in_valid_ff;
   bromm_pkg::req_item_type in_item_ff;
   logic                    rsp_valid_ff;
   bromm_pkg::rsp_item_type rsp_item_ff;
   bromm_pkg::rsp_item_type rsp_item_in;
   logic [5:0]              last_prg_ff;
   logic                    advance;

   // Move the held request on when the result register is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.kind    <= bromm_pkg::kind_type'(req_kind);
         in_item_ff.address <= req_address;
         in_item_ff.data    <= req_data;
      end
   end

   // Fixed top bank
   always_ff @(posedge clock) begin
      if (reset) begin
         last_prg_ff <= bromm_pkg::LAST_PRG_RESET;
      end else if (csr_valid && csr_ready) begin
         last_prg_ff <= csr_last_prg_bank;
      end
   end

   bromm_map u_map (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .item          (in_item_ff),
      .last_prg_bank (last_prg_ff),
      .result        (rsp_item_in)
   );

   // Result register: hold while stalled, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_irq          = rsp_item_ff.irq;
   assign rsp_bank         = rsp_item_ff.bank;
   assign rsp_ram_selected = rsp_item_ff.ram_selected;
   assign rsp_mirroring    = rsp_item_ff.mirroring;

endmodule

/* sv/bromm_map.sv */
// ----------------------------------------------------------------------------
// Banked ROM mapper state and lookup
// Holds the command latch, bank registers, mirroring, IRQ control and line
// counter; applies one request when told to and forms its response.
// ----------------------------------------------------------------------------
module bromm_map (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  bromm_pkg::req_item_type item,
   input  logic [5:0]             last_prg_bank,
   output bromm_pkg::rsp_item_type result
);

   logic [3:0]       cmd_ff,       cmd_in;
   logic [7:0][7:0]  pat_ff,       pat_in;
   logic [3:0][5:0]  prg_ff,       prg_in;
   logic             ram_mode_ff,  ram_mode_in;
   logic [1:0]       mirror_ff,    mirror_in;
   logic [7:0]       irq_ctrl_ff,  irq_ctrl_in;
   logic [15:0]      cnt_ff,       cnt_in;

   // Work out next state and the response for the request in hand
   always_comb begin
      cmd_in       = cmd_ff;
      pat_in       = pat_ff;
      prg_in       = prg_ff;
      ram_mode_in  = ram_mode_ff;
      mirror_in    = mirror_ff;
      irq_ctrl_in  = irq_ctrl_ff;
      cnt_in       = cnt_ff;
      result       = '0;

      unique case (item.kind)
         bromm_pkg::KIND_WRITE: begin
            if (item.address < bromm_pkg::ADDR_DATA_PORT) begin
               cmd_in = item.data[3:0];
            end else if (item.address < bromm_pkg::ADDR_IGNORED) begin
               unique case (cmd_ff)
                  bromm_pkg::CMD_WINDOW: begin
                     if (item.data[6]) begin
                        ram_mode_in = 1'b1;
                     end else begin
                        ram_mode_in = 1'b0;
                        prg_in[0]   = item.data[5:0];
                     end
                  end
                  bromm_pkg::CMD_PRG_8000,
                  bromm_pkg::CMD_PRG_A000,
                  bromm_pkg::CMD_PRG_C000: begin
                     prg_in[cmd_ff[1:0]] = item.data[5:0];
                  end
                  bromm_pkg::CMD_MIRROR:   mirror_in   = item.data[1:0];
                  bromm_pkg::CMD_IRQ_CTRL: irq_ctrl_in = item.data;
                  bromm_pkg::CMD_CNT_LO:   cnt_in      = {cnt_ff[15:8], item.data};
                  bromm_pkg::CMD_CNT_HI:   cnt_in      = {item.data, cnt_ff[7:0]};
                  // pattern bank commands
                  default:                 pat_in[cmd_ff[2:0]] = item.data;
               endcase
            end
         end
         bromm_pkg::KIND_TICK: begin
            // when bit 7 enables it, count the line down; on expiry reload and flag if bit 0 is set
            if (irq_ctrl_ff[7]) begin
               if (cnt_ff < bromm_pkg::LINE_CYCLES) begin
                  result.irq = irq_ctrl_ff[0];
                  cnt_in     = bromm_pkg::CNT_RELOAD;
               end else begin
                  cnt_in = cnt_ff - bromm_pkg::LINE_CYCLES;
               end
            end
         end
         bromm_pkg::KIND_CPU_LOOK: begin
            if (item.address >= bromm_pkg::ADDR_FIXED) begin
               result.bank = {2'b00, last_prg_bank};
            end else if (item.address >= bromm_pkg::ADDR_PRG) begin
               result.bank = {2'b00, prg_ff[2'(item.address[14:13] + 2'd1)]};
            end else if (item.address >= bromm_pkg::ADDR_WINDOW) begin
               if (ram_mode_ff) begin
                  result.ram_selected = 1'b1;
               end else begin
                  result.bank = {2'b00, prg_ff[0]};
               end
            end
         end
         bromm_pkg::KIND_PPU_LOOK: begin
            if (item.address < bromm_pkg::ADDR_PPU_TOP) begin
               result.bank = pat_ff[item.address[12:10]];
            end
         end
         default: ;
      endcase

      // mirroring reflects the state after this request
      result.mirroring = mirror_in;
   end

   // Hold mapper state; advance it when a request is applied
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff      <= '0;
         pat_ff      <= '0;
         prg_ff      <= {6'd2, 6'd1, 6'd0, 6'd0};
         ram_mode_ff <= 1'b0;
         mirror_ff   <= '0;
         irq_ctrl_ff <= '0;
         cnt_ff      <= '0;
      end else if (fire) begin
         cmd_ff      <= cmd_in;
         pat_ff      <= pat_in;
         prg_ff      <= prg_in;
         ram_mode_ff <= ram_mode_in;
         mirror_ff   <= mirror_in;
         irq_ctrl_ff <= irq_ctrl_in;
         cnt_ff      <= cnt_in;
      end
   end

endmodule

/* sv/bromm_checker.sv */
// ----------------------------------------------------------------------------
// Banked ROM mapper port checker
// Watches the core's ports for response consistency over time.
// ----------------------------------------------------------------------------
module bromm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_irq,
   input logic [7:0] rsp_bank,
   input logic       rsp_ram_selected,
   input logic [1:0] rsp_mirroring
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_irq) && $stable(rsp_bank)
         && $stable(rsp_ram_selected) && $stable(rsp_mirroring))
      else $error("stalled response changed");

   // RAM window select never comes with a bank number
   a_ram_no_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ram_selected |-> rsp_bank == 8'd0 && !rsp_irq)
      else $error("RAM select with bank or irq");

   // An IRQ pulse belongs to a line tick, which maps no bank
   a_irq_no_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq |-> rsp_bank == 8'd0)
      else $error("irq with bank");

   // Drop the response after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind banked_rom_mapper_with_line_irq_core bromm_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_irq          (rsp_irq),
   .rsp_bank         (rsp_bank),
   .rsp_ram_selected (rsp_ram_selected),
   .rsp_mirroring    (rsp_mirroring)
);

/* test/banked_rom_mapper_with_line_irq_core_tb.sv */
// ----------------------------------------------------------------------------
// Banked ROM mapper testbench
// Drives register writes, line ticks and CPU/PPU bank lookups into the mapper
// core, with random gaps on the request side and random stalls on the
// response side. A scoreboard tracks the mapper state, predicts each response
// and compares it, field by field, with what the core returns. The top bank
// register is rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module banked_rom_mapper_with_line_irq_core_tb;

   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 220;
   localparam int STALL_LIMIT = 2000;

   // Pattern bank commands are plain indexes below the window command
   localparam logic [3:0] CMD_CHR_7 = 4'h7;

   // Mapper state mirror and queue of predicted responses
   class bank_map_tracker;
      logic [3:0]  cmd;
      logic [7:0]  chr_banks [8];
      logic [5:0]  prg_banks [4];
      logic        ram_on;
      logic [1:0]  mirror;
      logic [7:0]  irq_ctrl;
      logic [15:0] line_cnt;
      logic [5:0]  top_bank;
      bromm_pkg::rsp_item_type expected_rsps [$];
      int unsigned error_count;

      function new();
         cmd = '0;
         foreach (chr_banks[i]) chr_banks[i] = '0;
         prg_banks[0] = 6'd0;
         prg_banks[1] = 6'd0;
         prg_banks[2] = 6'd1;
         prg_banks[3] = 6'd2;
         ram_on = 1'b0;
         mirror = '0;
         irq_ctrl = '0;
         line_cnt = '0;
         top_bank = bromm_pkg::LAST_PRG_RESET;
         error_count = 0;
      endfunction

      function void set_top_bank(logic [5:0] v);
         top_bank = v;
      endfunction

      // Apply a data byte to whatever the command latch selects
      function void apply_command(logic [7:0] v);
         if (cmd < bromm_pkg::CMD_WINDOW) begin
            chr_banks[cmd[2:0]] = v;
         end else begin
            unique case (cmd)
               bromm_pkg::CMD_WINDOW: begin
                  if (v[6]) begin
                     ram_on = 1'b1;
                  end else begin
                     ram_on = 1'b0;
                     prg_banks[0] = v[5:0];
                  end
               end
               bromm_pkg::CMD_PRG_8000,
               bromm_pkg::CMD_PRG_A000,
               bromm_pkg::CMD_PRG_C000: prg_banks[cmd[1:0]] = v[5:0];
               bromm_pkg::CMD_MIRROR:   mirror = v[1:0];
               bromm_pkg::CMD_IRQ_CTRL: irq_ctrl = v;
               bromm_pkg::CMD_CNT_LO:   line_cnt[7:0] = v;
               default:                 line_cnt[15:8] = v;
            endcase
         end
      endfunction

      // Update the state for one request and work out its response
      function bromm_pkg::rsp_item_type predict_outcome(bromm_pkg::kind_type kind,
                                                        logic [15:0] addr,
                                                        logic [7:0] data);
         bromm_pkg::rsp_item_type r;
         r = '0;
         unique case (kind)
            bromm_pkg::KIND_WRITE: begin
               if (addr < bromm_pkg::ADDR_DATA_PORT) cmd = data[3:0];
               else if (addr < bromm_pkg::ADDR_IGNORED) apply_command(data);
            end
            bromm_pkg::KIND_TICK: begin
               if (irq_ctrl[7]) begin
                  if (line_cnt < bromm_pkg::LINE_CYCLES) begin
                     r.irq = irq_ctrl[0];
                     line_cnt = bromm_pkg::CNT_RELOAD;
                  end else begin
                     line_cnt = line_cnt - bromm_pkg::LINE_CYCLES;
                  end
               end
            end
            bromm_pkg::KIND_CPU_LOOK: begin
               if (addr >= bromm_pkg::ADDR_FIXED) begin
                  r.bank = {2'b00, top_bank};
               end else if (addr >= bromm_pkg::ADDR_PRG) begin
                  r.bank = {2'b00, prg_banks[addr[14:13] + 2'd1]};
               end else if (addr >= bromm_pkg::ADDR_WINDOW) begin
                  if (ram_on) r.ram_selected = 1'b1;
                  else r.bank = {2'b00, prg_banks[0]};
               end
            end
            default: begin
               if (addr < bromm_pkg::ADDR_PPU_TOP) r.bank = chr_banks[addr[12:10]];
            end
         endcase
         r.mirroring = mirror;
         return r;
      endfunction

      function void note_request(bromm_pkg::kind_type kind, logic [15:0] addr,
                                 logic [7:0] data);
         expected_rsps.push_back(predict_outcome(kind, addr, data));
      endfunction

      function void check_response(bromm_pkg::rsp_item_type got);
         bromm_pkg::rsp_item_type exp;
         if (expected_rsps.size() == 0) begin
            $error("response with none expected: irq %0d bank %0d ram %0d mirroring %0d",
                   got.irq, got.bank, got.ram_selected, got.mirroring);
            error_count++;
            return;
         end
         exp = expected_rsps.pop_front();
         if (got.irq !== exp.irq) begin
            $error("irq mismatch: expected %0d, actual %0d", exp.irq, got.irq);
            error_count++;
         end
         if (got.bank !== exp.bank) begin
            $error("bank mismatch: expected %0d, actual %0d", exp.bank, got.bank);
            error_count++;
         end
         if (got.ram_selected !== exp.ram_selected) begin
            $error("ram_selected mismatch: expected %0d, actual %0d",
                   exp.ram_selected, got.ram_selected);
            error_count++;
         end
         if (got.mirroring !== exp.mirroring) begin
            $error("mirroring mismatch: expected %0d, actual %0d",
                   exp.mirroring, got.mirroring);
            error_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [15:0] req_address;
   logic [7:0]  req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_irq;
   logic [7:0]  rsp_bank;
   logic        rsp_ram_selected;
   logic [1:0]  rsp_mirroring;
   logic        csr_valid;
   logic        csr_ready;
   logic [5:0]  csr_last_prg_bank;

   bank_map_tracker tracker = new();
   bit          calm = 1'b0;
   int unsigned requests_sent = 0;
   int unsigned idle_cycles = 0;

   banked_rom_mapper_with_line_irq_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_address       (req_address),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_irq           (rsp_irq),
      .rsp_bank          (rsp_bank),
      .rsp_ram_selected  (rsp_ram_selected),
      .rsp_mirroring     (rsp_mirroring),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_last_prg_bank (csr_last_prg_bank)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stall the response side in short random bursts, never in the last phase
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && !reset && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   // Watch all three handshakes, feed the scoreboard and guard against hangs
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            tracker.check_response(bromm_pkg::rsp_item_type'({rsp_irq, rsp_bank,
                                                              rsp_ram_selected,
                                                              rsp_mirroring}));
         end
         if (req_valid && req_ready) begin
            tracker.note_request(bromm_pkg::kind_type'(req_kind), req_address, req_data);
         end
         if (csr_valid && csr_ready) tracker.set_top_bank(csr_last_prg_bank);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Present one request and hold it until the core takes it
   task automatic send_request(input bromm_pkg::kind_type kind, input logic [15:0] addr,
                               input logic [7:0] data);
      @(negedge clock);
      req_valid   = 1'b1;
      req_kind    = kind;
      req_address = addr;
      req_data    = data;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Latch a command, then write its data byte to the data port
   task automatic send_command(input logic [3:0] cmd, input logic [7:0] value);
      logic [7:0] latch_byte;
      latch_byte = {4'($urandom_range(0, 15)), cmd};
      send_request(bromm_pkg::KIND_WRITE,
                   16'($urandom_range(0, bromm_pkg::ADDR_DATA_PORT - 1)), latch_byte);
      send_request(bromm_pkg::KIND_WRITE,
                   16'($urandom_range(bromm_pkg::ADDR_DATA_PORT,
                                      bromm_pkg::ADDR_IGNORED - 1)), value);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // Drop valid and hold off until every predicted response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   task automatic write_top_bank(input logic [5:0] v);
      @(negedge clock);
      csr_valid         = 1'b1;
      csr_last_prg_bank = v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Extremes, pattern, window, mirroring, IRQ and counter commands, and the corner cases of the counter and windows
   task automatic run_directed();
      send_command(CMD_CHR_7, 8'hFF);
      send_request(bromm_pkg::KIND_PPU_LOOK, 16'h1FFF, 8'h00);
      send_request(bromm_pkg::KIND_PPU_LOOK, bromm_pkg::ADDR_PPU_TOP, 8'h00);
      send_command(bromm_pkg::CMD_WINDOW, 8'h40);
      send_request(bromm_pkg::KIND_CPU_LOOK, bromm_pkg::ADDR_WINDOW, 8'h00);
      send_request(bromm_pkg::KIND_WRITE, 16'(bromm_pkg::ADDR_IGNORED - 1), 8'hBF);
      send_request(bromm_pkg::KIND_CPU_LOOK, 16'(bromm_pkg::ADDR_PRG - 1), 8'h00);
      send_request(bromm_pkg::KIND_WRITE, bromm_pkg::ADDR_IGNORED, 8'h55);
      send_request(bromm_pkg::KIND_CPU_LOOK, 16'(bromm_pkg::ADDR_WINDOW - 1), 8'h00);
      send_request(bromm_pkg::KIND_CPU_LOOK, 16'hFFFF, 8'hFF);
      send_request(bromm_pkg::KIND_CPU_LOOK, 16'(bromm_pkg::ADDR_FIXED - 1), 8'h00);
      send_command(bromm_pkg::CMD_MIRROR, 8'hFF);
      send_command(bromm_pkg::CMD_IRQ_CTRL, 8'h81);
      send_request(bromm_pkg::KIND_TICK, 16'h0000, 8'h00);
      send_command(bromm_pkg::CMD_CNT_HI, 8'h00);
      send_command(bromm_pkg::CMD_CNT_LO, bromm_pkg::LINE_CYCLES[7:0]);
      send_request(bromm_pkg::KIND_TICK, 16'h0000, 8'h00);
      send_request(bromm_pkg::KIND_TICK, 16'h0000, 8'h00);
      send_command(bromm_pkg::CMD_IRQ_CTRL, 8'h01);
      send_request(bromm_pkg::KIND_TICK, 16'h0000, 8'h00);
   endtask

   // Mostly well-formed command pairs, ticks and lookups, with some noise
   task automatic random_step();
      int unsigned sel;
      logic [3:0]  cmd;
      logic [7:0]  value;
      logic [15:0] addr;
      sel = $urandom_range(0, 99);
      if (!calm && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 7));
      if (sel < 35) begin
         cmd   = 4'($urandom_range(0, 15));
         value = 8'($urandom_range(0, 255));
         // keep the counter small so that it expires often
         if (cmd == bromm_pkg::CMD_CNT_HI && $urandom_range(0, 3) != 0)
            value = 8'($urandom_range(0, 3));
         if (cmd == bromm_pkg::CMD_IRQ_CTRL && $urandom_range(0, 3) != 0) value[7] = 1'b1;
         send_command(cmd, value);
      end else if (sel < 55) begin
         send_request(bromm_pkg::KIND_TICK, 16'($urandom), 8'($urandom));
      end else if (sel < 70) begin
         send_request(bromm_pkg::KIND_CPU_LOOK, 16'($urandom), 8'($urandom));
      end else if (sel < 82) begin
         addr = 16'($urandom);
         if ($urandom_range(0, 4) != 0) addr[15:13] = 3'b000;
         send_request(bromm_pkg::KIND_PPU_LOOK, addr, 8'($urandom));
      end else begin
         send_request(bromm_pkg::kind_type'($urandom_range(0, 3)), 16'($urandom),
                      8'($urandom));
      end
   endtask

   initial begin
      int unsigned phase_end;
      logic [5:0]  top;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = bromm_pkg::KIND_WRITE;
      req_address       = '0;
      req_data          = '0;
      csr_valid         = 1'b0;
      csr_last_prg_bank = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      run_directed();

      // Rewrite the top bank between phases, only once the core has drained
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         if (phase == 0) top = 6'd0;
         else if (phase == 1) top = bromm_pkg::LAST_PRG_RESET;
         else top = 6'($urandom_range(0, 63));
         write_top_bank(top);
         calm = (phase == PHASES - 1);
         phase_end = requests_sent + PHASE_ITEMS;
         while (requests_sent < phase_end) random_step();
      end

      wait_drained();
      repeat (4) @(negedge clock);
      if (tracker.error_count == 0 && tracker.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/bromm_pkg.sv
sv/bromm_map.sv
sv/banked_rom_mapper_with_line_irq_core.sv
sv/bromm_checker.sv
test/banked_rom_mapper_with_line_irq_core_tb.sv
